FILE: src/tff_pkg.sv
package tff_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_COLS      = 2'd2;

    localparam logic [23:0] FILL_COLOR = 24'h0000FF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [16:0] painted_count;
        logic        out_of_bounds;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [8:0] data;
    } t_cfg_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED_RD,
        ST_SEED_WAIT,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_ISSUE,
        ST_NB_WAIT,
        ST_NB_CHECK,
        ST_OUT
    } t_state;

    function automatic logic chan_close(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] tol);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

endpackage

FILE: src/tff_if.sv
interface tff_in_if;
    logic                 valid;
    logic                 ready;
    tff_pkg::t_in_item    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tff_out_if;
    logic                 valid;
    logic                 ready;
    tff_pkg::t_out_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tff_cfg_if;
    logic                 valid;
    logic                 ready;
    tff_pkg::t_cfg_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/tolerance_flood_fill.sv
// 8-connected flood fill with per-channel color tolerance over an image held
// in on-chip memory. A pixel write, read or unused code gives its result from
// ST_OUT after the transfer; the input stays stalled until that result is
// taken. A fill first clears the visited map, one entry per cycle (skipped for
// a seed outside the area in use), reads the seed (ST_SEED_RD, ST_SEED_WAIT),
// and for each painted pixel pops the stack (ST_POP, ST_POP_WAIT), then checks
// each neighbor (ST_NB_ISSUE, ST_NB_WAIT, ST_NB_CHECK; ST_NB_ISSUE alone if
// outside the area); an empty stack ends the fill. The fill paints, and the
// stack pushes, as it goes. Results hold in an output register until taken.
// The image store, the visited map and the pixel stack each have one read and
// one write port; the stack holds one entry per pixel.
module tolerance_flood_fill #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tff_in_if.sink     i_in,
    tff_out_if.source  o_out,
    tff_cfg_if.sink    i_cfg
);
    localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AB = RB + CB;
    localparam int NPIX = MAX_ROWS * MAX_COLS;
    localparam int SB = $clog2(NPIX + 1);

    logic [23:0]   r_img [NPIX];
    logic          r_vis [NPIX];
    logic [AB-1:0] r_stk [NPIX];

    logic [7:0]  r_tol;
    logic [8:0]  r_rows, r_cols;
    logic [12:0] eff_rows, eff_cols;

    tff_pkg::t_state r_state, n_state;
    tff_pkg::t_in_item r_item;
    tff_pkg::t_out_item r_res, n_res;
    logic        r_oval;
    logic [AB-1:0] r_clr;
    logic [23:0] r_seed;
    logic [SB-1:0] r_top;
    logic [16:0] r_cnt;
    logic [12:0] r_cr, r_cc;
    logic [3:0]  r_k;
    logic [12:0] r_nr, r_nc;
    logic [23:0] r_rd;
    logic        r_vrd;
    logic [AB-1:0] r_spop;

    logic [12:0] nbr, nbc;
    logic        nb_ok;
    logic        oob;
    logic        in_xfer;
    logic [AB-1:0] a_in, a_nb, a_req, a_look, a_rd, a_pop;

    assign eff_rows = (13'(r_rows) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(r_rows);
    assign eff_cols = (13'(r_cols) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(r_cols);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == tff_pkg::ST_IDLE) && !r_oval;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign o_out.valid = r_oval;
    assign o_out.payload = r_res;

    assign oob = (13'(r_item.row) >= eff_rows) || (13'(r_item.col) >= eff_cols);

    function automatic logic [AB-1:0] addr(input logic [12:0] r, input logic [12:0] c);
        return AB'(r[RB-1:0]) * AB'(MAX_COLS) + AB'(c[CB-1:0]);
    endfunction

    // stack entries hold {row, col}
    function automatic logic [AB-1:0] rc(input logic [12:0] r, input logic [12:0] c);
        return {r[RB-1:0], c[CB-1:0]};
    endfunction

    assign a_in   = addr(13'(r_item.row), 13'(r_item.col));
    assign a_nb   = addr(r_nr, r_nc);
    assign a_req  = addr(13'(i_in.payload.row), 13'(i_in.payload.col));
    assign a_look = addr(nbr, nbc);
    assign a_pop  = addr(13'(r_spop[AB-1:CB]), 13'(r_spop[CB-1:0]));
    assign a_rd   = (r_state == tff_pkg::ST_IDLE)     ? a_req :
                    (r_state == tff_pkg::ST_NB_ISSUE) ? a_look :
                    (r_state == tff_pkg::ST_NB_WAIT)  ? a_nb : a_in;

    always_comb begin
        nbr = r_cr;
        nbc = r_cc;
        case (r_k)
            4'd0: begin nbr = r_cr - 13'd1; nbc = r_cc - 13'd1; end
            4'd1: begin nbr = r_cr - 13'd1; end
            4'd2: begin nbr = r_cr - 13'd1; nbc = r_cc + 13'd1; end
            4'd3: begin nbc = r_cc - 13'd1; end
            4'd4: begin nbc = r_cc + 13'd1; end
            4'd5: begin nbr = r_cr + 13'd1; nbc = r_cc - 13'd1; end
            4'd6: begin nbr = r_cr + 13'd1; end
            default: begin nbr = r_cr + 13'd1; nbc = r_cc + 13'd1; end
        endcase
        // negative wraps to large value, so one compare covers both ends
        nb_ok = (nbr < eff_rows) && (nbc < eff_cols);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tff_pkg::ST_IDLE:
                if (in_xfer) begin
                    n_state = tff_pkg::ST_OUT;
                    if (i_in.payload.operation == tff_pkg::OP_FILL)
                        n_state = tff_pkg::ST_CLEAR;
                end
            tff_pkg::ST_CLEAR:
                if (oob) n_state = tff_pkg::ST_OUT;
                else if (r_clr == AB'(NPIX - 1)) n_state = tff_pkg::ST_SEED_RD;
            tff_pkg::ST_SEED_RD:   n_state = tff_pkg::ST_SEED_WAIT;
            tff_pkg::ST_SEED_WAIT: n_state = tff_pkg::ST_POP;
            tff_pkg::ST_POP:
                if (r_top == '0) n_state = tff_pkg::ST_OUT;
                else n_state = tff_pkg::ST_POP_WAIT;
            tff_pkg::ST_POP_WAIT:  n_state = tff_pkg::ST_NB_ISSUE;
            tff_pkg::ST_NB_ISSUE:
                if (r_k == 4'd8) n_state = tff_pkg::ST_POP;
                else if (nb_ok) n_state = tff_pkg::ST_NB_WAIT;
            tff_pkg::ST_NB_WAIT:   n_state = tff_pkg::ST_NB_CHECK;
            tff_pkg::ST_NB_CHECK:  n_state = tff_pkg::ST_NB_ISSUE;
            tff_pkg::ST_OUT:       n_state = tff_pkg::ST_IDLE;
            default:               n_state = tff_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_res = '0;
        if (r_item.operation != tff_pkg::OP_NONE) begin
            if (oob) n_res.out_of_bounds = 1'b1;
            else if (r_item.operation == tff_pkg::OP_READ) begin
                n_res.red_out   = r_rd[23:16];
                n_res.green_out = r_rd[15:8];
                n_res.blue_out  = r_rd[7:0];
            end else if (r_item.operation == tff_pkg::OP_FILL)
                n_res.painted_count = r_cnt;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_rd   <= r_img[a_rd];
        r_vrd  <= r_vis[(r_state == tff_pkg::ST_NB_ISSUE) ? a_look : a_nb];
        r_spop <= r_stk[AB'(r_top - SB'(1))];
        if (r_state == tff_pkg::ST_OUT && r_item.operation == tff_pkg::OP_WRITE && !oob)
            r_img[a_in] <= {r_item.red_in, r_item.green_in, r_item.blue_in};
        else if (r_state == tff_pkg::ST_POP_WAIT)
            r_img[a_pop] <= tff_pkg::FILL_COLOR;
        if (r_state == tff_pkg::ST_CLEAR)
            r_vis[r_clr] <= 1'b0;
        else if (r_state == tff_pkg::ST_SEED_RD)
            r_vis[a_in] <= 1'b1;
        else if (r_state == tff_pkg::ST_NB_CHECK && !r_vrd
                 && tff_pkg::chan_close(r_rd[23:16], r_seed[23:16], r_tol)
                 && tff_pkg::chan_close(r_rd[15:8], r_seed[15:8], r_tol)
                 && tff_pkg::chan_close(r_rd[7:0], r_seed[7:0], r_tol))
            r_vis[a_nb] <= 1'b1;
        if (r_state == tff_pkg::ST_SEED_RD)
            r_stk[0] <= rc(13'(r_item.row), 13'(r_item.col));
        else if (r_state == tff_pkg::ST_NB_CHECK && !r_vrd
                 && tff_pkg::chan_close(r_rd[23:16], r_seed[23:16], r_tol)
                 && tff_pkg::chan_close(r_rd[15:8], r_seed[15:8], r_tol)
                 && tff_pkg::chan_close(r_rd[7:0], r_seed[7:0], r_tol))
            r_stk[AB'(r_top)] <= rc(r_nr, r_nc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tff_pkg::ST_IDLE;
            r_oval  <= 1'b0;
            r_tol   <= 8'd0;
            r_rows  <= 9'd256;
            r_cols  <= 9'd256;
            r_top   <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.index)
                    tff_pkg::CFG_TOLERANCE: r_tol <= i_cfg.payload.data[7:0];
                    tff_pkg::CFG_ROWS:      r_rows <= i_cfg.payload.data;
                    tff_pkg::CFG_COLS:      r_cols <= i_cfg.payload.data;
                    default: ;
                endcase
            end
            if (r_oval && o_out.ready) r_oval <= 1'b0;
            unique case (r_state)
                tff_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_item <= i_in.payload;
                        r_clr  <= '0;
                        r_cnt  <= '0;
                        r_top  <= '0;
                    end
                end
                tff_pkg::ST_CLEAR: r_clr <= r_clr + AB'(1);
                tff_pkg::ST_SEED_RD: r_top <= SB'(1);
                tff_pkg::ST_SEED_WAIT: r_seed <= r_rd;
                tff_pkg::ST_POP: begin
                    if (r_top != '0) r_top <= r_top - SB'(1);
                end
                tff_pkg::ST_POP_WAIT: begin
                    r_cr  <= 13'(r_spop[AB-1:CB]);
                    r_cc  <= 13'(r_spop[CB-1:0]);
                    r_k   <= 4'd0;
                    r_cnt <= r_cnt + 17'd1;
                end
                tff_pkg::ST_NB_ISSUE: begin
                    if (r_k != 4'd8) begin
                        r_nr <= nbr;
                        r_nc <= nbc;
                        r_k  <= r_k + 4'd1;
                    end
                end
                tff_pkg::ST_NB_WAIT: ;
                tff_pkg::ST_NB_CHECK: begin
                    if (!r_vrd
                        && tff_pkg::chan_close(r_rd[23:16], r_seed[23:16], r_tol)
                        && tff_pkg::chan_close(r_rd[15:8], r_seed[15:8], r_tol)
                        && tff_pkg::chan_close(r_rd[7:0], r_seed[7:0], r_tol))
                        r_top <= r_top + SB'(1);
                end
                tff_pkg::ST_OUT: begin
                    r_oval <= 1'b1;
                    r_res  <= n_res;
                end
                default: ;
            endcase
        end
    end

endmodule
